@@ rtl/lsms_pkg.sv @@
// Shared types and constants for the load-shedding mode selector.
package lsms_pkg;

    localparam int PCT_W         = 7;
    localparam int PCT_SCALE     = 100;
    localparam int FRAME_COUNT_W = 32;
    localparam int MODE_W        = 2;
    localparam int OUT_TDATA_W   = 8;
    localparam int CFG_INDEX_W   = 8;
    localparam int CFG_DATA_W    = 32;
    localparam int NUM_LEVELS    = 3;

    localparam int CAP_RESET         = 64;
    localparam int RECOVER_RESET     = 2;
    localparam int ANALYZE_PCT_RESET = 50;
    localparam int BALT_PCT_RESET    = 66;
    localparam int BALL_PCT_RESET    = 80;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_QUEUE_CAPACITY  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_RECOVER_DEPTH   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_ANALYZE_ALT_PCT = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_BYPASS_ALT_PCT  = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_BYPASS_ALL_PCT  = CFG_INDEX_W'(4);

    // Threshold level slots.
    localparam int LVL_ANALYZE_ALT = 0;
    localparam int LVL_BYPASS_ALT  = 1;
    localparam int LVL_BYPASS_ALL  = 2;

    // Output mode codes.
    localparam logic [MODE_W-1:0] CODE_NORMAL      = 2'd0;
    localparam logic [MODE_W-1:0] CODE_ANALYZE_ALT = 2'd1;
    localparam logic [MODE_W-1:0] CODE_BYPASS_ALT  = 2'd2;
    localparam logic [MODE_W-1:0] CODE_BYPASS_ALL  = 2'd3;

    typedef enum logic [3:0] {
        MODE_NORMAL      = 4'b0001,
        MODE_ANALYZE_ALT = 4'b0010,
        MODE_BYPASS_ALT  = 4'b0100,
        MODE_BYPASS_ALL  = 4'b1000
    } mode_state_t;

    function automatic logic [MODE_W-1:0] mode_code(input mode_state_t m);
        logic [MODE_W-1:0] c;
        case (m)
            MODE_NORMAL:      c = CODE_NORMAL;
            MODE_ANALYZE_ALT: c = CODE_ANALYZE_ALT;
            MODE_BYPASS_ALT:  c = CODE_BYPASS_ALT;
            MODE_BYPASS_ALL:  c = CODE_BYPASS_ALL;
            default:          c = CODE_NORMAL;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/load_shed_mode_selector.sv @@
// Top level of the load-shedding mode selector.
//
// Channel   Direction  Transaction
// s_axis    in         fill_level and frame_count for one frame
// m_axis    out        new mode and bypass flag for that frame
// cfg       in         one configuration register write
//
// Each transaction on s_axis yields one on m_axis. One transaction is taken every cycle while
// m_axis is not stalled; the input register and the output register form a two-stage pipeline,
// and the held mode is updated as each result enters the output register.
// A configuration write takes effect for any frame accepted from the next cycle on.
// Reset restores the register defaults and returns the held mode to normal.
// A stall on m_axis holds the result and backs up into s_axis once the input register is full.
module load_shed_mode_selector
    import lsms_pkg::*;
#(
    parameter int DEPTH_WIDTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // fill_level, frame_count
    input  logic [((DEPTH_WIDTH+FRAME_COUNT_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // mode, bypass
    output logic [OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    logic [DEPTH_WIDTH-1:0]       capacity;
    logic [DEPTH_WIDTH-1:0]       recover;
    logic [DEPTH_WIDTH+PCT_W-1:0] level_prod [NUM_LEVELS];
    logic [MODE_W-1:0]            mode;
    logic                         bypass;

    lsms_cfg #(
        .DEPTH_WIDTH(DEPTH_WIDTH)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .capacity   (capacity),
        .recover    (recover),
        .level_prod (level_prod)
    );

    lsms_core #(
        .DEPTH_WIDTH(DEPTH_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_depth     (s_axis_tdata[DEPTH_WIDTH-1:0]),
        .in_frame_lsb (s_axis_tdata[DEPTH_WIDTH]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_mode     (mode),
        .out_bypass   (bypass),
        .capacity     (capacity),
        .recover      (recover),
        .level_prod   (level_prod)
    );

    assign m_axis_tdata = {(OUT_TDATA_W-MODE_W-1)'(0), bypass, mode};

endmodule

@@ rtl/lsms_cfg.sv @@
// Configuration registers and the scaled threshold products derived from them.
module lsms_cfg
    import lsms_pkg::*;
#(
    parameter int DEPTH_WIDTH = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [CFG_INDEX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]            cfg_data,
    output logic [DEPTH_WIDTH-1:0]           capacity,
    output logic [DEPTH_WIDTH-1:0]           recover,
    output logic [DEPTH_WIDTH+PCT_W-1:0]     level_prod [NUM_LEVELS]
);

    localparam int SW = DEPTH_WIDTH + PCT_W;

    logic [DEPTH_WIDTH-1:0] cap_reg;
    logic [DEPTH_WIDTH-1:0] recover_reg;
    logic [PCT_W-1:0]       pct_reg [NUM_LEVELS];
    logic [SW-1:0]          prod_reg [NUM_LEVELS];
    logic                   wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg                  <= DEPTH_WIDTH'(CAP_RESET);
            recover_reg              <= DEPTH_WIDTH'(RECOVER_RESET);
            pct_reg[LVL_ANALYZE_ALT] <= PCT_W'(ANALYZE_PCT_RESET);
            pct_reg[LVL_BYPASS_ALT]  <= PCT_W'(BALT_PCT_RESET);
            pct_reg[LVL_BYPASS_ALL]  <= PCT_W'(BALL_PCT_RESET);
        end
        else if (wr)
        begin
            case (cfg_index)
                REG_QUEUE_CAPACITY:  cap_reg <= cfg_data[DEPTH_WIDTH-1:0];
                REG_RECOVER_DEPTH:   recover_reg <= cfg_data[DEPTH_WIDTH-1:0];
                REG_ANALYZE_ALT_PCT: pct_reg[LVL_ANALYZE_ALT] <= cfg_data[PCT_W-1:0];
                REG_BYPASS_ALT_PCT:  pct_reg[LVL_BYPASS_ALT] <= cfg_data[PCT_W-1:0];
                REG_BYPASS_ALL_PCT:  pct_reg[LVL_BYPASS_ALL] <= cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // The products follow the registers in the next cycle and need no reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            prod_reg[i] <= SW'(cap_reg) * SW'(pct_reg[i]);
        end
    end

    assign capacity   = cap_reg;
    assign recover    = recover_reg;
    assign level_prod = prod_reg;

endmodule

@@ rtl/lsms_core.sv @@
// Input register, mode update logic and output register of the mode selector.
module lsms_core
    import lsms_pkg::*;
#(
    parameter int DEPTH_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [DEPTH_WIDTH-1:0]       in_depth,
    input  logic                         in_frame_lsb,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [MODE_W-1:0]            out_mode,
    output logic                         out_bypass,
    input  logic [DEPTH_WIDTH-1:0]       capacity,
    input  logic [DEPTH_WIDTH-1:0]       recover,
    input  logic [DEPTH_WIDTH+PCT_W-1:0] level_prod [NUM_LEVELS]
);

    localparam int SW = DEPTH_WIDTH + PCT_W;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [DEPTH_WIDTH-1:0] s1_depth_reg;
    logic [SW-1:0]          s1_scaled_reg;
    logic                   s1_even_reg;
    logic [SW-1:0]          scaled;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [MODE_W-1:0]      out_mode_reg;
    logic                   out_bypass_reg;

    mode_state_t            mode_reg;
    mode_state_t            mode_next;
    logic [NUM_LEVELS-1:0]  reach;
    logic                   bypass_next;
    logic                   accept;
    logic                   advance;

    // Depth times one hundred, built from shifts.
    assign scaled = (SW'(in_depth) << 6) + (SW'(in_depth) << 5) + (SW'(in_depth) << 2);

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    // A depth reaches a level when depth*100 >= capacity*pct, with the
    // threshold clamped to the range from one to the capacity.
    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            reach[i] = (s1_depth_reg >= capacity)
                    || ((s1_depth_reg != '0) && (s1_scaled_reg >= level_prod[i]));
        end
    end

    always_comb
    begin
        if (s1_depth_reg <= recover)
        begin
            mode_next = MODE_NORMAL;
        end
        else if (reach[LVL_BYPASS_ALL] || mode_reg == MODE_BYPASS_ALL)
        begin
            mode_next = MODE_BYPASS_ALL;
        end
        else if (reach[LVL_BYPASS_ALT] || mode_reg == MODE_BYPASS_ALT)
        begin
            mode_next = MODE_BYPASS_ALT;
        end
        else if (reach[LVL_ANALYZE_ALT] || mode_reg == MODE_ANALYZE_ALT)
        begin
            mode_next = MODE_ANALYZE_ALT;
        end
        else
        begin
            mode_next = MODE_NORMAL;
        end
    end

    always_comb
    begin
        case (mode_next)
            MODE_BYPASS_ALL: bypass_next = 1'b1;
            MODE_BYPASS_ALT: bypass_next = s1_even_reg;
            default:         bypass_next = 1'b0;
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_NORMAL;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                mode_reg <= mode_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_depth_reg  <= in_depth;
            s1_scaled_reg <= scaled;
            s1_even_reg   <= !in_frame_lsb;
        end
        if (advance)
        begin
            out_mode_reg   <= mode_code(mode_next);
            out_bypass_reg <= bypass_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_mode   = out_mode_reg;
    assign out_bypass = out_bypass_reg;

    a_bypass_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_bypass_reg |->
            (out_mode_reg == CODE_BYPASS_ALT) || (out_mode_reg == CODE_BYPASS_ALL))
        else $error("bypass flag set outside the bypass modes");

    a_recover: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (s1_depth_reg <= recover) |=> out_mode_reg == CODE_NORMAL)
        else $error("depth at or below recover did not give normal mode");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (s1_depth_reg > recover) && (s1_depth_reg >= capacity)
            |=> out_mode_reg == CODE_BYPASS_ALL)
        else $error("depth at capacity did not give bypass-all");

    a_held_mode: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> mode_code(mode_reg) == out_mode_reg)
        else $error("held mode differs from the reported mode");

endmodule
